[hdl/swc_pkg.sv]
// Shared constants, the tap transaction tag and the kernel coefficient table
// for the sliding window convolver. No dependencies.
package swc_pkg;

	localparam int SWC_WINDOW = 20;
	localparam int SWC_TAPS = 10;

	localparam int SAMPLE_W = 16;
	localparam int COEF_W = 15;
	localparam int PROD_W = SAMPLE_W + COEF_W;
	// Sum of up to 10 products (SWC_TAPS), plus one bit above the result width for saturation
	localparam int ACC_W = PROD_W + 6;
	localparam int FILT_W = 36;
	localparam int POS_W = 5;
	localparam int KBITS = 4;
	localparam int PBITS = 6;

	// Tag carried alongside each tap read through the MAC pipeline
	typedef struct packed {
		logic [KBITS-1:0] k;
		logic [PBITS-1:0] pos;
		logic             first;
		logic             fin;
		logic             last;
	} tag_t;

	// Kernel in u9.6, taps past the tenth are zero
	function automatic logic [COEF_W-1:0] swc_coef(input logic [KBITS-1:0] k);
		logic [COEF_W-1:0] c;
		case (k)
			4'd0:    c = 15'd26280;
			4'd1:    c = 15'd26647;
			4'd2:    c = 15'd17731;
			4'd3:    c = 15'd13221;
			4'd4:    c = 15'd8821;
			4'd5:    c = 15'd6501;
			4'd6:    c = 15'd7477;
			4'd7:    c = 15'd11018;
			4'd8:    c = 15'd26889;
			4'd9:    c = 15'd27866;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

[hdl/swc_mac.sv]
// Shared multiply-accumulate unit with saturation and the result register.
// Depends on swc_pkg.
module swc_mac import swc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s1_valid,
	input  tag_t                s1_tag,
	input  logic [SAMPLE_W-1:0] s1_data,
	output logic                adv,
	output logic [POS_W-1:0]    position,
	output logic [FILT_W-1:0]   filtered,
	output logic                last,
	output logic                result_valid,
	input  logic                result_stall
);

	logic [PROD_W-1:0] prod_s2;
	tag_t              tag_s2;
	logic              val_s2;
	logic [ACC_W-1:0]  acc_q;
	logic [ACC_W-1:0]  acc_sum;
	logic [FILT_W-1:0] sat_sum;
	logic              out_valid_q;
	logic [POS_W-1:0]  pos_q;
	logic [FILT_W-1:0] filt_q;
	logic              last_q;

	// Whole pipeline holds while a finished result waits on a stalled output
	assign adv = !out_valid_q || !result_stall;

	// Accumulate, restarting on the first tap of each output
	always_comb begin
		acc_sum = (tag_s2.first ? '0 : acc_q) + ACC_W'(prod_s2);
		if (|acc_sum[ACC_W-1:FILT_W]) begin
			sat_sum = '1;
		end else begin
			sat_sum = acc_sum[FILT_W-1:0];
		end
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			val_s2 <= s1_valid;
			out_valid_q <= val_s2 && tag_s2.fin;
		end
	end

	// Datapath: product, accumulator, result
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= PROD_W'(s1_data) * PROD_W'(swc_coef(s1_tag.k));
			tag_s2 <= s1_tag;
			if (val_s2) begin
				acc_q <= acc_sum;
			end
			if (val_s2 && tag_s2.fin) begin
				pos_q <= tag_s2.pos[POS_W-1:0];
				filt_q <= sat_sum;
				last_q <= tag_s2.last;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign position = pos_q;
	assign filtered = filt_q;
	assign last = last_q;

endmodule

[hdl/sliding_window_convolver.sv]
// Sliding window causal FIR: window store, tap sequencer and the MAC unit.
// Depends on swc_pkg and swc_mac.
// Path: a result passes the tap read, product and result registers.
// Throughput: one tap per cycle unless a stalled output holds the pipeline; a run
// issues sum over i of min(i, TAPS-1)+1 taps (155 by default) on the single shared
// MAC; the next sample is taken the cycle after the last tap issues.
// Reset: window reads as zeros through per-entry valid bits; no clearing pass.
module sliding_window_convolver import swc_pkg::*; #(
	parameter int WINDOW = SWC_WINDOW,
	parameter int TAPS = SWC_TAPS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic                sample_valid,
	output logic                sample_stall,
	output logic [POS_W-1:0]    position,
	output logic [FILT_W-1:0]   filtered,
	output logic                last,
	output logic                result_valid,
	input  logic                result_stall
);

	localparam int AW = $clog2(WINDOW);
	localparam int KW = (TAPS > 1) ? $clog2(TAPS) : 1;

	logic [SAMPLE_W-1:0] win_mem [WINDOW];
	logic [WINDOW-1:0]   win_vld_q;
	logic [AW-1:0]       head_q;
	logic                busy_q;
	logic [AW-1:0]       i_q;
	logic [KW-1:0]       k_q;
	logic [KW-1:0]       kmax;
	logic [AW-1:0]       diff;
	logic [AW:0]         rd_sum;
	logic [AW-1:0]       rd_addr;
	logic                fin;
	logic                last_i;
	logic                accept;
	logic                issue;
	logic                adv;
	logic [SAMPLE_W-1:0] rd_data_s1;
	logic                ent_vld_s1;
	logic                val_s1;
	tag_t                tag_s1;
	logic [SAMPLE_W-1:0] data_s1;
	tag_t                tag_nxt;

	assign accept = sample_valid && !busy_q;
	assign sample_stall = busy_q;
	assign issue = busy_q && adv;

	// Tap address: logical entry i-k counted from the oldest slot at head
	always_comb begin
		if (32'(i_q) >= TAPS - 1) begin
			kmax = KW'(TAPS - 1);
		end else begin
			kmax = KW'(i_q);
		end
		diff = i_q - AW'(k_q);
		rd_sum = (AW+1)'(head_q) + (AW+1)'(diff);
		if (rd_sum >= (AW+1)'(WINDOW)) begin
			rd_addr = AW'(rd_sum - (AW+1)'(WINDOW));
		end else begin
			rd_addr = rd_sum[AW-1:0];
		end
		fin = (k_q == kmax);
		last_i = (i_q == AW'(WINDOW - 1));
		tag_nxt.k = KBITS'(k_q);
		tag_nxt.pos = PBITS'(i_q);
		tag_nxt.first = (k_q == '0);
		tag_nxt.fin = fin;
		tag_nxt.last = fin && last_i;
	end

	// Sequencer, head pointer and entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			head_q <= '0;
			i_q <= '0;
			k_q <= '0;
			win_vld_q <= '0;
			val_s1 <= 1'b0;
			ent_vld_s1 <= 1'b0;
		end else begin
			if (accept) begin
				win_vld_q[head_q] <= 1'b1;
				head_q <= (head_q == AW'(WINDOW - 1)) ? '0 : head_q + 1'b1;
				busy_q <= 1'b1;
				i_q <= '0;
				k_q <= '0;
			end else if (issue) begin
				if (fin) begin
					k_q <= '0;
					if (last_i) begin
						busy_q <= 1'b0;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end else begin
					k_q <= k_q + 1'b1;
				end
			end
			if (adv) begin
				val_s1 <= busy_q;
				ent_vld_s1 <= win_vld_q[rd_addr];
			end
		end
	end

	// Window memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (accept) begin
			win_mem[head_q] <= sample;
		end
		if (issue) begin
			rd_data_s1 <= win_mem[rd_addr];
			tag_s1 <= tag_nxt;
		end
	end

	assign data_s1 = ent_vld_s1 ? rd_data_s1 : '0;

	swc_mac u_mac (
		.clk          (clk),
		.arst_n       (arst_n),
		.s1_valid     (val_s1),
		.s1_tag       (tag_s1),
		.s1_data      (data_s1),
		.adv          (adv),
		.position     (position),
		.filtered     (filtered),
		.last         (last),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

	// Checks
	a_run_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q)
		else $error("run did not start after sample transaction");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> position == POS_W'(WINDOW - 1))
		else $error("last flag on wrong position");

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= AW'(WINDOW - 1))
		else $error("head pointer out of range");

endmodule
